### src/stbs_pkg.sv
// stbs_pkg: shared types and constants of the sorted table binary search block
// used by stbs_ctrl, stbs_dp and sorted_table_binary_search_top
`default_nettype none

package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int BND_W       = IDX_W + 2;
   localparam int DATA_W      = 32;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDR,
      ST_CMP,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_wr;
      logic start;
      logic read;
      logic compare;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic range_empty;
      logic equal;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

### src/stbs_ctrl.sv
// stbs_ctrl: state machine that sequences loads and binary search probes
// depends on stbs_pkg
`default_nettype none

module stbs_ctrl
   import stbs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_op,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            if (sts.range_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = sts.equal ? ST_DONE : ST_ADDR;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/stbs_dp.sv
// stbs_dp: table memory, search bounds, compare and result register
// depends on stbs_pkg
`default_nettype none

module stbs_dp
   import stbs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output sts_type                      sts,
   input  wire logic [IDX_W-1:0]         req_entry_index,
   input  wire logic signed [DATA_W-1:0] req_entry_value,
   input  wire logic signed [DATA_W-1:0] req_search_key,
   input  wire logic                     csr_valid,
   input  wire logic [CNT_W-1:0]         csr_entries_in_use,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_found,
   output logic [IDX_W-1:0]              rsp_position
);

   logic [DATA_W-1:0]        mem [TABLE_DEPTH];
   logic [DATA_W-1:0]        rd_ff;
   logic [CNT_W-1:0]         count_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [BND_W-1:0]  lo_ff;
   logic signed [BND_W-1:0]  hi_ff;
   logic [IDX_W-1:0]         mid_ff;
   logic                     hit_ff;
   logic [IDX_W-1:0]         pos_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [IDX_W-1:0]         rsp_position_ff;

   logic [CNT_W-1:0]         count_sat;
   logic signed [BND_W-1:0]  span;
   logic signed [BND_W-1:0]  mid;
   logic signed [BND_W-1:0]  mid_ext;
   logic                     is_lt;
   logic                     is_eq;

   always_comb begin
      count_sat = (count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_ff;
      span      = hi_ff - lo_ff;
      mid       = lo_ff + (span >>> 1);
      mid_ext   = $signed({2'b00, mid_ff});
      is_eq     = ($signed(rd_ff) == key_ff);
      is_lt     = ($signed(rd_ff) < key_ff);
      sts.range_empty = (lo_ff > hi_ff);
      sts.equal       = is_eq;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[req_entry_index] <= req_entry_value;
      end
      if (cmd.read) begin
         rd_ff <= mem[mid[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_entries_in_use;
      end
   end

   // search bounds and hit tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff  <= '0;
         hi_ff  <= '0;
         hit_ff <= 1'b0;
         pos_ff <= '0;
      end else if (cmd.start) begin
         lo_ff  <= '0;
         hi_ff  <= $signed({1'b0, count_sat}) - BND_W'(1);
         hit_ff <= 1'b0;
         pos_ff <= '0;
      end else if (cmd.compare) begin
         if (is_eq) begin
            hit_ff <= 1'b1;
            pos_ff <= mid_ff;
         end else if (is_lt) begin
            lo_ff <= mid_ext + BND_W'(1);
         end else begin
            hi_ff <= mid_ext - BND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_search_key;
      end
      if (cmd.read) begin
         mid_ff <= mid[IDX_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff    <= hit_ff;
         rsp_position_ff <= pos_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

`default_nettype wire

### src/sorted_table_binary_search_top.sv
// sorted_table_binary_search_top: top level of the sorted table search block
// depends on stbs_pkg, stbs_ctrl and stbs_dp
//
// usage
//   req channel: a word with req_op load writes req_entry_value at
//   req_entry_index and gives no rsp word; a word with req_op
//   search looks for req_search_key among entries 0 to n-1, n being
//   csr_entries_in_use (saturated to the table depth), and gives one rsp word
//   csr channel: always ready, write only while the block is idle
//   rsp channel: rsp_found and rsp_position (zero when not found)
//   search sequence: each probe is a registered memory read, then a
//   compare, at most 11 probes for 1024 entries; a hit ends the search, a
//   miss ends when the range is found empty; the result is then posted to
//   the output register as soon as that register is free
//   request flow: one item at a time; a load leaves the block idle, a search
//   holds req_ready low until its result is posted
//   the result sits in an output register, so a stalled receiver only blocks
//   once the next search has finished
//   reset: control, bounds and entries_in_use clear; table contents are
//   undefined until written
`default_nettype none

module sorted_table_binary_search_top
   import stbs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_op,
   input  wire logic [IDX_W-1:0]         req_entry_index,
   input  wire logic signed [DATA_W-1:0] req_entry_value,
   input  wire logic signed [DATA_W-1:0] req_search_key,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_found,
   output logic [IDX_W-1:0]              rsp_position,
   // configuration channel
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CNT_W-1:0]         csr_entries_in_use
);

   cmd_type cmd;
   sts_type sts;

   // register write accepted every cycle
   assign csr_ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stbs_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_search_key     (req_search_key),
      .csr_valid          (csr_valid),
      .csr_entries_in_use (csr_entries_in_use),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_position       (rsp_position)
   );

endmodule

`default_nettype wire

### verif/stbs_tb_pkg.sv
// stbs_tb_pkg: scoreboard class for the sorted table binary search testbench
// depends on stbs_pkg for the table depth, field widths and the op codes

package stbs_tb_pkg;
   import stbs_pkg::*;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
   } lookup_result_type;

   class lookup_scoreboard;
      logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
      logic [CNT_W-1:0]         live_count;
      lookup_result_type        expected_lookups [$];
      int                       errors;
      int                       loads_seen;
      int                       lookups_checked;
      int                       hits_checked;

      function new();
         live_count      = '0;
         errors          = 0;
         loads_seen      = 0;
         lookups_checked = 0;
         hits_checked    = 0;
      endfunction

      function void set_count(input logic [CNT_W-1:0] n);
         live_count = n;
      endfunction

      // probe sequence of the search over entries 0 to n-1
      function lookup_result_type predict_lookup(input logic signed [DATA_W-1:0] key);
         lookup_result_type r;
         int                n;
         int                lo;
         int                hi;
         int                mid;
         r = '0;
         n = live_count;
         if (n > TABLE_DEPTH) n = TABLE_DEPTH;
         lo = 0;
         hi = n - 1;
         while (lo <= hi && !r.found) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] == key) begin
               r.found    = 1'b1;
               r.position = mid[IDX_W-1:0];
            end else if (entries[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
         return r;
      endfunction

      function void note_request(input op_type op, input logic [IDX_W-1:0] idx,
                                 input logic signed [DATA_W-1:0] val,
                                 input logic signed [DATA_W-1:0] key);
         if (op == OP_LOAD) begin
            entries[idx] = val;
            loads_seen++;
         end else begin
            expected_lookups.push_back(predict_lookup(key));
         end
      endfunction

      function void check_response(input logic found, input logic [IDX_W-1:0] position);
         lookup_result_type want;
         if (expected_lookups.size() == 0) begin
            errors++;
            $display("%0t: result word with no search pending, expected none, %s",
                     $time, "got one");
            $display("%0t: unexpected word found %0b position %0d",
                     $time, found, position);
         end else begin
            want = expected_lookups.pop_front();
            lookups_checked++;
            if (want.found) hits_checked++;
            if (found !== want.found) begin
               errors++;
               $display("%0t: found mismatch, expected %0b, got %0b",
                        $time, want.found, found);
            end
            if (position !== want.position) begin
               errors++;
               $display("%0t: position mismatch, expected %0d, got %0d",
                        $time, want.position, position);
            end
         end
      endfunction

      function int outstanding();
         return expected_lookups.size();
      endfunction
   endclass

endpackage

### verif/tb_sorted_table_binary_search_top.sv
// tb_sorted_table_binary_search_top: self-checking testbench of the sorted table search block
// depends on stbs_pkg, stbs_tb_pkg and sorted_table_binary_search_top

module tb_sorted_table_binary_search_top;
   import stbs_pkg::*;
   import stbs_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 1750;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_op = 1'b0;
   logic [IDX_W-1:0]         req_entry_index = '0;
   logic signed [DATA_W-1:0] req_entry_value = '0;
   logic signed [DATA_W-1:0] req_search_key = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_found;
   logic [IDX_W-1:0]         rsp_position;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CNT_W-1:0]         csr_entries_in_use = '0;

   lookup_scoreboard sb = new();

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // long receiver hold-off, counted down by the receiver process
   int hold_left = 0;
   int items_sent = 0;
   int tables_tried = 0;
   longint cycle_count = 0;

   // scratch for building a table image
   logic signed [DATA_W-1:0] fill_vals [TABLE_DEPTH];
   int                       fill_order [TABLE_DEPTH];

   sorted_table_binary_search_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_search_key     (req_search_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_position       (rsp_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entries_in_use (csr_entries_in_use)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run guard: a correct run ends far below this
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_sorted_table_binary_search_top: errors");
            $finish;
         end
      end
   end

   // result side: check each accepted word, then pick ready for the next cycle
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_found, rsp_position);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // offer one request word, valid stays high until accepted
   task automatic push_word(input op_type op, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val,
                            input logic signed [DATA_W-1:0] key);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_search_key  <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, val, key);
      items_sent++;
   endtask

   // unused fields carry random bits so they toggle too
   task automatic load_entry(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] val);
      push_word(OP_LOAD, idx, val, $urandom);
   endtask

   task automatic find_key(input logic signed [DATA_W-1:0] key);
      push_word(OP_SEARCH, IDX_W'($urandom), $urandom, key);
   endtask

   // drop valid, let every search come back, then cover a trailing load
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called after settle, so the block is idle
   task automatic write_count(input logic [CNT_W-1:0] n);
      csr_entries_in_use <= n;
      csr_valid          <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_count(n);
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode % 4)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 88;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 88;
         end
         default: begin
            send_idle_pct  = 10;
            recv_stall_pct = 10;
         end
      endcase
   endtask

   // load entries 0 to count-1, ascending unless scrambled contents are asked
   task automatic fill_table(input int count, input int span, input bit shuffle,
                             input bit unsorted);
      longint acc;
      int     j;
      int     tmp;
      if ($urandom_range(0, 3) == 0 || count == TABLE_DEPTH) acc = VAL_MIN;
      else acc = longint'($signed($urandom));
      for (int i = 0; i < count; i++) begin
         if (unsorted) begin
            fill_vals[i] = $urandom;
         end else begin
            if (acc > VAL_MAX) acc = VAL_MAX;
            fill_vals[i] = acc[DATA_W-1:0];
            // a zero step gives duplicate entries now and then
            acc = acc + longint'($urandom_range(0, span));
         end
         fill_order[i] = i;
      end
      // load order need not follow the index
      if (shuffle) begin
         for (int i = count - 1; i > 0; i--) begin
            j             = $urandom_range(0, i);
            tmp           = fill_order[i];
            fill_order[i] = fill_order[j];
            fill_order[j] = tmp;
         end
      end
      for (int i = 0; i < count; i++)
         load_entry(fill_order[i][IDX_W-1:0], fill_vals[fill_order[i]]);
   endtask

   // mostly keys that sit in the live range, some neighbors, some noise
   function automatic logic signed [DATA_W-1:0] pick_key();
      int                       n;
      int                       r;
      logic signed [DATA_W-1:0] k;
      n = sb.live_count;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      r = $urandom_range(0, 9);
      if (n == 0 || r >= 8) begin
         k = $urandom;
      end else begin
         k = sb.entries[$urandom_range(0, n - 1)];
         if (r == 6) k = k + 1;
         else if (r == 7) k = k - 1;
      end
      return k;
   endfunction

   // searches with an odd overwrite inside the live range, which keeps it written
   task automatic run_lookups(input int count);
      int n;
      n = sb.live_count;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      for (int i = 0; i < count; i++) begin
         if (n > 0 && $urandom_range(0, 15) == 0)
            load_entry(IDX_W'($urandom_range(0, n - 1)), pick_key());
         else
            find_key(pick_key());
      end
   endtask

   initial begin : stimulus
      int n;
      int r;
      int span;
      int random_start;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // empty table after reset: nothing is read, nothing found
      find_key(VAL_MIN);
      find_key(32'sd0);

      // small sorted table with both extremes, plus the top index
      load_entry(10'd0, VAL_MIN);
      load_entry(10'd1, -32'sd1000);
      load_entry(10'd2, -32'sd1);
      load_entry(10'd3, 32'sd0);
      load_entry(10'd4, 32'sd5);
      load_entry(10'd5, 32'sd1000);
      load_entry(10'd6, VAL_MAX);
      load_entry(10'd1023, -32'sd1);
      settle();
      write_count(11'd7);
      // hits at both ends and the middle, misses between entries and just inside the ends
      find_key(VAL_MIN);
      find_key(VAL_MAX);
      find_key(32'sd0);
      find_key(-32'sd1000);
      find_key(32'sd1000);
      find_key(32'sd4);
      find_key(VAL_MIN + 1);
      find_key(VAL_MAX - 1);
      settle();

      // single live entry
      write_count(11'd1);
      find_key(VAL_MIN);
      find_key(32'sd5);

      // break the order, the probe sequence still decides the answer
      load_entry(10'd2, VAL_MAX);
      settle();
      write_count(11'd7);
      find_key(VAL_MAX);
      find_key(-32'sd1);
      settle();

      // count written back to zero
      write_count(11'd0);
      find_key(VAL_MIN);
      settle();

      // ---- random part ----
      random_start = items_sent;

      // whole table, sorted across the full value range, loaded out of order
      set_idle_mode(0);
      fill_table(TABLE_DEPTH, 8388607, 1'b1, 1'b0);
      settle();
      write_count(11'd1024);
      tables_tried++;
      for (int m = 0; m < 4; m++) begin
         set_idle_mode(m);
         run_lookups(40);
      end
      settle();

      // count above the depth saturates
      write_count(11'd2047);
      tables_tried++;
      set_idle_mode(1);
      run_lookups(50);
      settle();

      // receiver holds off while searches keep coming, so the block backs up
      write_count(11'd1025);
      tables_tried++;
      set_idle_mode(0);
      hold_left = 400;
      run_lookups(40);
      set_idle_mode(3);
      run_lookups(30);
      settle();

      // many small tables under every idling mode
      for (int phase = 0; items_sent - random_start < RANDOM_ITEMS; phase++) begin
         r = $urandom_range(0, 9);
         if (r == 0) n = 0;
         else if (r == 1) n = $urandom_range(1, 2);
         else n = $urandom_range(3, 48);
         case ($urandom_range(0, 3))
            0:       span = 2;
            1:       span = 1000;
            2:       span = 1 << 20;
            default: span = 1 << 27;
         endcase
         set_idle_mode(phase);
         if (n > 0) fill_table(n, span, $urandom_range(0, 1) == 1, $urandom_range(0, 5) == 0);
         settle();
         write_count(n[CNT_W-1:0]);
         tables_tried++;
         run_lookups(2 * n + 4);
         settle();
      end

      $display("covered %0d table loads and %0d searches (%0d hits) over %0d table sizes",
               sb.loads_seen, sb.lookups_checked, sb.hits_checked, tables_tried);
      $display("idling modes: none, sender idle, receiver stall, both, plus one long hold-off");
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("tb_sorted_table_binary_search_top: clean");
      else
         $display("tb_sorted_table_binary_search_top: errors");
      $finish;
   end

endmodule

### sim.f
src/stbs_pkg.sv
src/stbs_ctrl.sv
src/stbs_dp.sv
src/sorted_table_binary_search_top.sv
verif/stbs_tb_pkg.sv
verif/tb_sorted_table_binary_search_top.sv
